// ----- hdl/wcs_pkg.sv -----
// ----------------------------------------------------------------------------
// wcs_pkg
// shared widths, register indexes and control types of the simplifier
// ----------------------------------------------------------------------------
package wcs_pkg;

    localparam int COORD_W     = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 4;
    localparam int LIMB_W      = 33;
    localparam int LIMB_IDX_W  = 2;
    localparam int PROD_W      = 2 * LIMB_W;
    localparam int OP_W        = 3 * LIMB_W;
    localparam int LEN_W       = 2 * LIMB_W;
    localparam int DSQ_W       = 4 * LIMB_W;
    localparam int ACC_W       = 168;
    localparam int COS_SHIFT   = 30;
    localparam int N_MAC_STEPS = 18;
    localparam int STEP_W      = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COS_THRESHOLD = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] MIN_LENGTH_RST    = CFG_W'(256);
    localparam logic [CFG_W-1:0] COS_THRESHOLD_RST = CFG_W'(32276);

    typedef enum logic [3:0] {
        SRC_ZERO,
        SRC_MX1,
        SRC_MY1,
        SRC_MX2,
        SRC_MY2,
        SRC_C2,
        SRC_L1,
        SRC_L2,
        SRC_DOT,
        SRC_CL
    } t_src;

    typedef enum logic [1:0] {
        SG_POS,
        SG_X,
        SG_Y
    } t_sgn;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_L1,
        DST_L2,
        DST_DOT,
        DST_CL,
        DST_DSQ
    } t_dst;

    typedef enum logic {
        EM_PEND,
        EM_CUR
    } t_emit;

    typedef enum logic [1:0] {
        KP_NONE,
        KP_CUR,
        KP_PEND
    } t_kept;

    typedef struct packed {
        t_src                  a_sel;
        logic [LIMB_IDX_W-1:0] a_limb;
        t_src                  b_sel;
        logic [LIMB_IDX_W-1:0] b_limb;
        logic                  clr;
        t_sgn                  sgn;
        t_dst                  dst;
    } t_mac_cmd;

    typedef struct packed {
        logic     cur_load;
        logic     diff_load;
        t_mac_cmd mac;
        logic     emit;
        t_emit    emit_sel;
        logic     emit_final;
        t_kept    kept_sel;
        logic     pend_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic keep;
    } t_dp_stat;

endpackage

// ----- hdl/wcs_if.sv -----
// ----------------------------------------------------------------------------
// wcs_if
// valid/ready channels of the simplifier: waypoints in, kept waypoints out,
// register writes
// ----------------------------------------------------------------------------
interface wcs_point_if;
    import wcs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      is_final;

    modport source (output valid, point_x, point_y, point_z, is_final, input ready);
    modport sink   (input valid, point_x, point_y, point_z, is_final, output ready);
endinterface

interface wcs_result_if;
    import wcs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      out_final;

    modport source (output valid, out_x, out_y, out_z, out_final, input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_final, output ready);
endinterface

interface wcs_cfg_if;
    import wcs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface

// ----- hdl/wcs_dpath.sv -----
// ----------------------------------------------------------------------------
// wcs_dpath
// point registers, segment differences, shared 33x33 multiplier with a wide
// accumulator, turn decision and the output register
// ----------------------------------------------------------------------------
module wcs_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wcs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wcs_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic signed [wcs_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [wcs_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [wcs_pkg::COORD_W-1:0] i_point_z,
    input  wcs_pkg::t_dp_cmd                  i_cmd,
    output wcs_pkg::t_dp_stat                 o_stat,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [wcs_pkg::COORD_W-1:0] o_out_x,
    output logic signed [wcs_pkg::COORD_W-1:0] o_out_y,
    output logic signed [wcs_pkg::COORD_W-1:0] o_out_z,
    output logic                              o_out_final
);
    import wcs_pkg::*;

    function automatic logic [COORD_W-1:0] f_mag(input logic [COORD_W:0] d);
        logic [COORD_W:0] n;
        n = (COORD_W + 1)'(0) - d;
        return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
    endfunction

    function automatic logic [LIMB_W-1:0] f_limb(input logic [OP_W-1:0] v,
                                                 input logic [LIMB_IDX_W-1:0] k);
        logic [LIMB_W-1:0] l;
        unique case (k)
            LIMB_IDX_W'(0): l = v[LIMB_W-1:0];
            LIMB_IDX_W'(1): l = v[2*LIMB_W-1:LIMB_W];
            LIMB_IDX_W'(2): l = v[3*LIMB_W-1:2*LIMB_W];
            default:        l = '0;
        endcase
        return l;
    endfunction

    logic [CFG_W-1:0]     r_min_length;
    logic [CFG_W-1:0]     r_cos_threshold;
    logic [2*CFG_W-1:0]   r_minsq;
    logic [2*CFG_W-1:0]   r_c2;

    logic [COORD_W-1:0]   r_cur_x, r_cur_y, r_cur_z;
    logic [COORD_W-1:0]   r_pend_x, r_pend_y, r_pend_z;
    logic [COORD_W-1:0]   r_kept_x, r_kept_y;

    logic [COORD_W-1:0]   r_mx1, r_my1, r_mx2, r_my2;
    logic                 r_sx, r_sy;
    logic [COORD_W:0]     w_dx1, w_dy1, w_dx2, w_dy2;

    logic [LEN_W-1:0]     r_l1, r_l2, r_dot;
    logic                 r_dneg;
    logic [OP_W-1:0]      r_cl;
    logic [DSQ_W-1:0]     r_dsq;

    logic [OP_W-1:0]      w_a_op, w_b_op;
    logic [LIMB_W-1:0]    w_a, w_b;
    logic [PROD_W-1:0]    w_prod;
    logic                 w_sub;

    logic [PROD_W-1:0]    r_prod;
    logic [LIMB_IDX_W-1:0] r_p_sh;
    logic                 r_p_sub;
    logic                 r_p_clr;
    t_dst                 r_p_dst;

    logic [ACC_W-1:0]     r_acc;
    logic [ACC_W-1:0]     w_addend, w_base;
    logic [LEN_W:0]       w_dot_s, w_dot_n;
    logic [ACC_W-1:0]     w_lhs;
    logic                 w_short;

    logic                 r_out_valid;
    logic [COORD_W-1:0]   r_out_x, r_out_y, r_out_z;
    logic                 r_out_final;

    // configuration registers and their squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length    <= MIN_LENGTH_RST;
            r_cos_threshold <= COS_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_MIN_LENGTH) begin
                r_min_length <= i_cfg_wdata;
            end else if (i_cfg_index == CFG_COS_THRESHOLD) begin
                r_cos_threshold <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_minsq <= (2*CFG_W)'(r_min_length) * (2*CFG_W)'(r_min_length);
        r_c2    <= (2*CFG_W)'(r_cos_threshold) * (2*CFG_W)'(r_cos_threshold);
    end

    // point registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cur_load) begin
            r_cur_x <= i_point_x;
            r_cur_y <= i_point_y;
            r_cur_z <= i_point_z;
        end
        if (i_cmd.pend_load) begin
            r_pend_x <= r_cur_x;
            r_pend_y <= r_cur_y;
            r_pend_z <= r_cur_z;
        end
        unique case (i_cmd.kept_sel)
            KP_CUR: begin
                r_kept_x <= r_cur_x;
                r_kept_y <= r_cur_y;
            end
            KP_PEND: begin
                r_kept_x <= r_pend_x;
                r_kept_y <= r_pend_y;
            end
            default: begin
            end
        endcase
    end

    // segment differences, 33 bit signed
    assign w_dx1 = {r_pend_x[COORD_W-1], r_pend_x} - {r_kept_x[COORD_W-1], r_kept_x};
    assign w_dy1 = {r_pend_y[COORD_W-1], r_pend_y} - {r_kept_y[COORD_W-1], r_kept_y};
    assign w_dx2 = {r_cur_x[COORD_W-1], r_cur_x} - {r_pend_x[COORD_W-1], r_pend_x};
    assign w_dy2 = {r_cur_y[COORD_W-1], r_cur_y} - {r_pend_y[COORD_W-1], r_pend_y};

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff_load) begin
            r_mx1 <= f_mag(w_dx1);
            r_my1 <= f_mag(w_dy1);
            r_mx2 <= f_mag(w_dx2);
            r_my2 <= f_mag(w_dy2);
            r_sx  <= w_dx1[COORD_W] ^ w_dx2[COORD_W];
            r_sy  <= w_dy1[COORD_W] ^ w_dy2[COORD_W];
        end
    end

    // operand selection
    always_comb begin
        unique case (i_cmd.mac.a_sel)
            SRC_ZERO: w_a_op = '0;
            SRC_MX1:  w_a_op = OP_W'(r_mx1);
            SRC_MY1:  w_a_op = OP_W'(r_my1);
            SRC_MX2:  w_a_op = OP_W'(r_mx2);
            SRC_MY2:  w_a_op = OP_W'(r_my2);
            SRC_C2:   w_a_op = OP_W'(r_c2);
            SRC_L1:   w_a_op = OP_W'(r_l1);
            SRC_L2:   w_a_op = OP_W'(r_l2);
            SRC_DOT:  w_a_op = OP_W'(r_dot);
            SRC_CL:   w_a_op = r_cl;
            default:  w_a_op = '0;
        endcase
        unique case (i_cmd.mac.b_sel)
            SRC_ZERO: w_b_op = '0;
            SRC_MX1:  w_b_op = OP_W'(r_mx1);
            SRC_MY1:  w_b_op = OP_W'(r_my1);
            SRC_MX2:  w_b_op = OP_W'(r_mx2);
            SRC_MY2:  w_b_op = OP_W'(r_my2);
            SRC_C2:   w_b_op = OP_W'(r_c2);
            SRC_L1:   w_b_op = OP_W'(r_l1);
            SRC_L2:   w_b_op = OP_W'(r_l2);
            SRC_DOT:  w_b_op = OP_W'(r_dot);
            SRC_CL:   w_b_op = r_cl;
            default:  w_b_op = '0;
        endcase
        unique case (i_cmd.mac.sgn)
            SG_X:    w_sub = r_sx;
            SG_Y:    w_sub = r_sy;
            default: w_sub = 1'b0;
        endcase
    end

    assign w_a    = f_limb(w_a_op, i_cmd.mac.a_limb);
    assign w_b    = f_limb(w_b_op, i_cmd.mac.b_limb);
    assign w_prod = PROD_W'(w_a) * PROD_W'(w_b);

    // multiplier stage
    always_ff @(posedge i_clk) begin
        r_prod  <= w_prod;
        r_p_sh  <= LIMB_IDX_W'(i_cmd.mac.a_limb + i_cmd.mac.b_limb);
        r_p_sub <= w_sub;
        if (!i_rst_n) begin
            r_p_clr <= 1'b0;
            r_p_dst <= DST_NONE;
        end else begin
            r_p_clr <= i_cmd.mac.clr;
            r_p_dst <= i_cmd.mac.dst;
        end
    end

    // accumulator stage
    always_comb begin
        unique case (r_p_sh)
            LIMB_IDX_W'(0): w_addend = ACC_W'(r_prod);
            LIMB_IDX_W'(1): w_addend = ACC_W'(r_prod) << LIMB_W;
            LIMB_IDX_W'(2): w_addend = ACC_W'(r_prod) << (2 * LIMB_W);
            LIMB_IDX_W'(3): w_addend = ACC_W'(r_prod) << (3 * LIMB_W);
        endcase
    end

    assign w_base  = r_p_clr ? '0 : r_acc;
    assign w_dot_s = r_acc[LEN_W:0];
    assign w_dot_n = (LEN_W + 1)'(0) - w_dot_s;

    always_ff @(posedge i_clk) begin
        r_acc <= w_base + (w_addend ^ {ACC_W{r_p_sub}}) + ACC_W'(r_p_sub);
        unique case (r_p_dst)
            DST_L1:  r_l1 <= r_acc[LEN_W-1:0];
            DST_L2:  r_l2 <= r_acc[LEN_W-1:0];
            DST_DOT: begin
                r_dot  <= w_dot_s[LEN_W] ? w_dot_n[LEN_W-1:0] : w_dot_s[LEN_W-1:0];
                r_dneg <= w_dot_s[LEN_W];
            end
            DST_CL:  r_cl  <= r_acc[OP_W-1:0];
            DST_DSQ: r_dsq <= r_acc[DSQ_W-1:0];
            default: begin
            end
        endcase
    end

    // turn decision, accumulator holds the right side
    assign w_short = (r_l1 < LEN_W'(r_minsq)) || (r_l2 < LEN_W'(r_minsq));
    assign w_lhs   = ACC_W'({r_dsq, {COS_SHIFT{1'b0}}});

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            unique case (i_cmd.emit_sel)
                EM_PEND: begin
                    r_out_x <= r_pend_x;
                    r_out_y <= r_pend_y;
                    r_out_z <= r_pend_z;
                end
                EM_CUR: begin
                    r_out_x <= r_cur_x;
                    r_out_y <= r_cur_y;
                    r_out_z <= r_cur_z;
                end
            endcase
            r_out_final <= i_cmd.emit_final;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_stat.keep     = !w_short && (r_dneg || (w_lhs < r_acc));

    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_out_z     = r_out_z;
    assign o_out_final = r_out_final;

endmodule

// ----- hdl/wcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// wcs_ctrl
// path state and sequencer: steps the multiply-accumulate schedule and
// decides which waypoints go to the output register
// ----------------------------------------------------------------------------
module wcs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_final,
    output logic              o_in_ready,
    output wcs_pkg::t_dp_cmd  o_cmd,
    input  wcs_pkg::t_dp_stat i_stat
);
    import wcs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_MAC,
        S_FLUSH,
        S_DECIDE,
        S_FINISH
    } t_state;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(N_MAC_STEPS - 1);
    localparam logic [1:0] PTS_START = 2'd0;
    localparam logic [1:0] PTS_FIRST = 2'd1;
    localparam logic [1:0] PTS_PEND  = 2'd2;

    localparam t_mac_cmd MAC_NOP = '{
        a_sel: SRC_ZERO, a_limb: '0, b_sel: SRC_ZERO, b_limb: '0,
        clr: 1'b0, sgn: SG_POS, dst: DST_NONE
    };

    function automatic t_mac_cmd f_mac(input t_src a, input logic [LIMB_IDX_W-1:0] al,
                                       input t_src b, input logic [LIMB_IDX_W-1:0] bl,
                                       input logic clr, input t_sgn sg, input t_dst d);
        t_mac_cmd c;
        c.a_sel  = a;
        c.a_limb = al;
        c.b_sel  = b;
        c.b_limb = bl;
        c.clr    = clr;
        c.sgn    = sg;
        c.dst    = d;
        return c;
    endfunction

    // squared lengths, dot product, cos^2 * l1, dot^2, then cos^2 * l1 * l2
    function automatic t_mac_cmd f_rom(input logic [STEP_W-1:0] s);
        t_mac_cmd c;
        unique case (s)
            5'd0:    c = f_mac(SRC_MX1, 2'd0, SRC_MX1, 2'd0, 1'b1, SG_POS, DST_NONE);
            5'd1:    c = f_mac(SRC_MY1, 2'd0, SRC_MY1, 2'd0, 1'b0, SG_POS, DST_NONE);
            5'd2:    c = f_mac(SRC_MX2, 2'd0, SRC_MX2, 2'd0, 1'b1, SG_POS, DST_L1);
            5'd3:    c = f_mac(SRC_MY2, 2'd0, SRC_MY2, 2'd0, 1'b0, SG_POS, DST_NONE);
            5'd4:    c = f_mac(SRC_MX1, 2'd0, SRC_MX2, 2'd0, 1'b1, SG_X,   DST_L2);
            5'd5:    c = f_mac(SRC_MY1, 2'd0, SRC_MY2, 2'd0, 1'b0, SG_Y,   DST_NONE);
            5'd6:    c = f_mac(SRC_C2,  2'd0, SRC_L1,  2'd0, 1'b1, SG_POS, DST_DOT);
            5'd7:    c = f_mac(SRC_C2,  2'd0, SRC_L1,  2'd1, 1'b0, SG_POS, DST_NONE);
            5'd8:    c = f_mac(SRC_DOT, 2'd0, SRC_DOT, 2'd0, 1'b1, SG_POS, DST_CL);
            5'd9:    c = f_mac(SRC_DOT, 2'd0, SRC_DOT, 2'd1, 1'b0, SG_POS, DST_NONE);
            5'd10:   c = f_mac(SRC_DOT, 2'd1, SRC_DOT, 2'd0, 1'b0, SG_POS, DST_NONE);
            5'd11:   c = f_mac(SRC_DOT, 2'd1, SRC_DOT, 2'd1, 1'b0, SG_POS, DST_NONE);
            5'd12:   c = f_mac(SRC_CL,  2'd0, SRC_L2,  2'd0, 1'b1, SG_POS, DST_DSQ);
            5'd13:   c = f_mac(SRC_CL,  2'd0, SRC_L2,  2'd1, 1'b0, SG_POS, DST_NONE);
            5'd14:   c = f_mac(SRC_CL,  2'd1, SRC_L2,  2'd0, 1'b0, SG_POS, DST_NONE);
            5'd15:   c = f_mac(SRC_CL,  2'd1, SRC_L2,  2'd1, 1'b0, SG_POS, DST_NONE);
            5'd16:   c = f_mac(SRC_CL,  2'd2, SRC_L2,  2'd0, 1'b0, SG_POS, DST_NONE);
            5'd17:   c = f_mac(SRC_CL,  2'd2, SRC_L2,  2'd1, 1'b0, SG_POS, DST_NONE);
            default: c = MAC_NOP;
        endcase
        return c;
    endfunction

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [1:0]        r_pts, n_pts;
    logic              r_fin, n_fin;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_pts   = r_pts;
        n_fin   = r_fin;

        o_cmd.cur_load   = 1'b0;
        o_cmd.diff_load  = 1'b0;
        o_cmd.mac        = MAC_NOP;
        o_cmd.emit       = 1'b0;
        o_cmd.emit_sel   = EM_CUR;
        o_cmd.emit_final = 1'b0;
        o_cmd.kept_sel   = KP_NONE;
        o_cmd.pend_load  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cur_load = 1'b1;
                    n_fin          = i_in_final;
                    n_state        = (r_pts >= PTS_PEND) ? S_DIFF : S_FINISH;
                end
            end
            S_DIFF: begin
                o_cmd.diff_load = 1'b1;
                n_step          = '0;
                n_state         = S_MAC;
            end
            S_MAC: begin
                o_cmd.mac = f_rom(r_step);
                if (r_step == LAST_STEP) begin
                    n_state = S_FLUSH;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_FLUSH: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (!i_stat.keep) begin
                    n_state = S_FINISH;
                end else if (i_stat.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_sel   = EM_PEND;
                    o_cmd.emit_final = 1'b0;
                    o_cmd.kept_sel   = KP_PEND;
                    n_state          = S_FINISH;
                end
            end
            S_FINISH: begin
                if (r_fin) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit       = 1'b1;
                        o_cmd.emit_final = 1'b1;
                        n_pts            = PTS_START;
                        n_state          = S_IDLE;
                    end
                end else if (r_pts == PTS_START) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.kept_sel = KP_CUR;
                        n_pts          = PTS_FIRST;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.pend_load = 1'b1;
                    n_pts           = PTS_PEND;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_pts   <= PTS_START;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_pts   <= n_pts;
            r_fin   <= n_fin;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

`ifndef ASSERT_OFF
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("result written while output register busy");

    a_pts_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pts != 2'd3)
        else $error("points seen out of range");

    a_pend_judged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && r_pts == PTS_PEND) |=> r_state == S_DIFF)
        else $error("pending point not judged");

    a_sched_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC && r_step == LAST_STEP) |=> (r_state == S_FLUSH))
        else $error("schedule overran");
`endif

endmodule

// ----- hdl/waypoint_collinear_simplifier.sv -----
// a point that settles no pending point: the first or last point of a path goes to the output
// register once it is free, any other becomes the pending point; a point that settles a pending
// point: diff state, 18 steps on the shared 33x33 multiplier, flush and decide, and a kept
// middle point goes to the output register once it is free; a new point is taken only when idle
// reset: synchronous active low; path state cleared, min_length 256, cos_threshold 32276
// ----------------------------------------------------------------------------
// waypoint_collinear_simplifier
// drops waypoints that do not turn the path or sit too close to their
// neighbours; first and last points of each path always pass
// ----------------------------------------------------------------------------
module waypoint_collinear_simplifier (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wcs_point_if.sink     i_point,
    wcs_result_if.source  o_result,
    wcs_cfg_if.sink       i_cfg
);
    import wcs_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    assign i_point.ready = w_in_ready;
    assign i_cfg.ready   = 1'b1;

    wcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_point.valid),
        .i_in_final (i_point.is_final),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    wcs_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_wdata (i_cfg.wdata),
        .i_point_x   (i_point.point_x),
        .i_point_y   (i_point.point_y),
        .i_point_z   (i_point.point_z),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_out_x     (o_result.out_x),
        .o_out_y     (o_result.out_y),
        .o_out_z     (o_result.out_z),
        .o_out_final (o_result.out_final)
    );

endmodule
